FILE: design/gbs_pkg.sv
// ----------------------------------------------------------------------------
// Gate burst sequencer package
// Shared types and constants for the gate burst sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    // Longest burst length minus one, in passes over the span.
    localparam logic [4:0] PASS_LIMIT = 5'd23;

    // Stepping patterns held in the latched settings.
    typedef enum logic [1:0] {
        MODE_FORWARD  = 2'd0,
        MODE_PENDULUM = 2'd1,
        MODE_RANDOM   = 2'd2
    } t_mode;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_SPAN   = 2'd0,
        REG_COUNT  = 2'd1,
        REG_MODE   = 2'd2,
        REG_INVERT = 2'd3
    } t_reg_idx;

    // Configuration registers as written by software.
    typedef struct packed {
        logic [2:0] span;
        logic [4:0] burst_passes;
        logic [1:0] pattern_mode;
        logic       invert;
    } t_cfg;

    // Settings captured at the start of a burst, already clamped.
    typedef struct packed {
        logic [2:0] span;
        logic [4:0] count;
        t_mode      mode;
        logic       invert;
    } t_latched;

    // Status of the sequencer core.
    typedef struct packed {
        logic  running;
        t_mode mode;
    } t_status;

endpackage

`default_nettype wire

FILE: design/gbs_if.sv
// ----------------------------------------------------------------------------
// Gate burst sequencer channel interfaces
// Valid/ready channels for tick transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbs_in_if;
    logic        valid;
    logic        ready;
    logic        reset_level;
    logic        trigger_level;
    logic        clock_level;
    logic [15:0] random_word;

    modport source (output valid, output reset_level, output trigger_level,
                    output clock_level, output random_word, input ready);
    modport sink   (input valid, input reset_level, input trigger_level,
                    input clock_level, input random_word, output ready);
endinterface

interface gbs_out_if #(
    parameter int N_OUT = 6
);
    logic             valid;
    logic             ready;
    logic [N_OUT-1:0] gates;
    logic             busy_res;

    modport source (output valid, output gates, output busy_res, input ready);
    modport sink   (input valid, input gates, input busy_res, output ready);
endinterface

`default_nettype wire

FILE: design/gbs_core.sv
// ----------------------------------------------------------------------------
// Gate burst sequencer core
// Burst state and the combinational next-state logic for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_core #(
    parameter int OUTPUTS = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_reset_level,
    input  wire logic               i_trigger_level,
    input  wire logic               i_clock_level,
    input  wire logic [15:0]        i_random_word,
    input  wire gbs_pkg::t_cfg      i_cfg,
    output logic [OUTPUTS-1:0]      o_gates_next,
    output logic                    o_running_next,
    output logic [OUTPUTS-1:0]      o_gates,
    output gbs_pkg::t_status        o_status
);

    localparam logic [2:0] SPAN_MAX = (OUTPUTS > 7) ? 3'd7 : 3'(OUTPUTS);

    logic [OUTPUTS-1:0]  r_gates, n_gates;
    logic                r_running, n_running;
    logic                r_armed, n_armed;
    logic                r_first, n_first;
    logic [4:0]          r_pass, n_pass;
    logic [2:0]          r_pos, n_pos;
    logic                r_back, n_back;
    gbs_pkg::t_latched   r_set, n_set;
    logic                r_prev_rst, n_prev_rst;
    logic                r_prev_trg, n_prev_trg;
    logic                r_prev_clk, n_prev_clk;

    gbs_pkg::t_latched   w_latch;

    function automatic logic [OUTPUTS-1:0] f_sel(input logic [2:0] p);
        logic [OUTPUTS-1:0] v;
        for (int k = 0; k < OUTPUTS; k++) begin
            v[k] = (32'(p) == k);
        end
        return v;
    endfunction

    function automatic logic [4:0] f_bump(input logic [4:0] p);
        return (p == 5'd31) ? p : p + 5'd1;
    endfunction

    // Settings as they are captured at the start of a burst.
    always_comb begin
        if (i_cfg.span == 3'd0) begin
            w_latch.span = 3'd1;
        end else if (i_cfg.span > SPAN_MAX) begin
            w_latch.span = SPAN_MAX;
        end else begin
            w_latch.span = i_cfg.span;
        end
        w_latch.count = (i_cfg.burst_passes > gbs_pkg::PASS_LIMIT) ?
                        gbs_pkg::PASS_LIMIT : i_cfg.burst_passes;
        case (i_cfg.pattern_mode)
            2'(gbs_pkg::MODE_PENDULUM): w_latch.mode = gbs_pkg::MODE_PENDULUM;
            2'(gbs_pkg::MODE_RANDOM):   w_latch.mode = gbs_pkg::MODE_RANDOM;
            default:                    w_latch.mode = gbs_pkg::MODE_FORWARD;
        endcase
        w_latch.invert = i_cfg.invert;
    end

    always_comb begin
        logic        rst_rise;
        logic        clk_rise;
        logic        clk_fall;
        logic [18:0] prod;
        logic [3:0]  pos_inc;

        n_gates    = r_gates;
        n_running  = r_running;
        n_armed    = r_armed;
        n_first    = r_first;
        n_pass     = r_pass;
        n_pos      = r_pos;
        n_back     = r_back;
        n_set      = r_set;
        n_prev_rst = r_prev_rst;
        n_prev_trg = r_prev_trg;
        n_prev_clk = r_prev_clk;
        prod       = '0;
        pos_inc    = '0;

        rst_rise = i_reset_level & ~r_prev_rst;
        clk_rise = i_clock_level & ~r_prev_clk;
        clk_fall = ~i_clock_level & r_prev_clk;

        if (i_accept) begin
            n_prev_rst = i_reset_level;
            if (rst_rise) begin
                // A reset edge leaves the trigger and clock history untouched.
                n_gates   = '0;
                n_running = 1'b0;
                n_armed   = 1'b0;
            end else begin
                // The trigger is only watched while no burst is pending or running.
                if (!r_running && !r_armed) begin
                    n_armed    = i_trigger_level & ~r_prev_trg;
                    n_prev_trg = i_trigger_level;
                end
                n_prev_clk = i_clock_level;
                if (clk_rise) begin
                    if (!r_running && n_armed) begin
                        n_set     = w_latch;
                        n_first   = 1'b1;
                        n_pass    = 5'd0;
                        n_pos     = 3'd0;
                        n_back    = 1'b0;
                        n_armed   = 1'b0;
                        n_running = 1'b1;
                    end
                    if (n_running) begin
                        if (n_set.mode == gbs_pkg::MODE_RANDOM) begin
                            prod    = 19'(i_random_word) * 19'(n_set.span);
                            n_pos   = prod[18:16];
                            n_gates = n_gates | f_sel(n_pos);
                            n_pass  = f_bump(n_pass);
                        end else begin
                            pos_inc = {1'b0, n_pos} + 4'd1;
                            if (n_first) begin
                                n_first = 1'b0;
                            end else if (n_set.mode == gbs_pkg::MODE_FORWARD) begin
                                if (pos_inc >= {1'b0, n_set.span}) begin
                                    n_pos  = 3'd0;
                                    n_pass = f_bump(n_pass);
                                end else begin
                                    n_pos = pos_inc[2:0];
                                end
                            end else if (n_back) begin
                                if (n_pos == 3'd0) begin
                                    // Without invert the forward leg resumes at output one.
                                    n_pos  = n_set.invert ? 3'd0 : 3'd1;
                                    n_back = 1'b0;
                                    n_pass = f_bump(n_pass);
                                end else begin
                                    n_pos = n_pos - 3'd1;
                                end
                            end else begin
                                if (pos_inc >= {1'b0, n_set.span}) begin
                                    if (n_set.span > 3'd1) begin
                                        n_pos = n_set.invert ? n_pos : n_pos - 3'd1;
                                    end else begin
                                        n_pos = 3'd0;
                                    end
                                    n_back = 1'b1;
                                    n_pass = f_bump(n_pass);
                                end else begin
                                    n_pos = pos_inc[2:0];
                                end
                            end
                            if (n_pass <= n_set.count) begin
                                if (n_set.invert) begin
                                    n_gates = n_gates ^ f_sel(n_pos);
                                end else begin
                                    n_gates = n_gates | f_sel(n_pos);
                                end
                            end
                        end
                    end
                end else if (r_running && clk_fall) begin
                    if (r_pass > r_set.count) begin
                        n_gates   = '0;
                        n_running = 1'b0;
                    end else if (r_set.mode == gbs_pkg::MODE_RANDOM || !r_set.invert) begin
                        n_gates = n_gates & ~f_sel(r_pos);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gates    <= '0;
            r_running  <= 1'b0;
            r_armed    <= 1'b0;
            r_first    <= 1'b0;
            r_pass     <= 5'd0;
            r_pos      <= 3'd0;
            r_back     <= 1'b0;
            r_set      <= '0;
            r_prev_rst <= 1'b0;
            r_prev_trg <= 1'b0;
            r_prev_clk <= 1'b0;
        end else begin
            r_gates    <= n_gates;
            r_running  <= n_running;
            r_armed    <= n_armed;
            r_first    <= n_first;
            r_pass     <= n_pass;
            r_pos      <= n_pos;
            r_back     <= n_back;
            r_set      <= n_set;
            r_prev_rst <= n_prev_rst;
            r_prev_trg <= n_prev_trg;
            r_prev_clk <= n_prev_clk;
        end
    end

    assign o_gates_next     = n_gates;
    assign o_running_next   = n_running;
    assign o_gates          = r_gates;
    assign o_status.running = r_running;
    assign o_status.mode    = r_set.mode;

endmodule

`default_nettype wire

FILE: design/gate_burst_sequencer_top.sv
// ----------------------------------------------------------------------------
// Gate burst sequencer
// Steps a gate across a row of outputs in bursts started by a trigger edge.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Payload
//  i_in      sink       valid / ready   reset_level, trigger_level, clock_level,
//                                       random_word
//  o_out     source     valid / ready   gates, busy_res
//  APB       slave      psel / penable  span, burst_passes, pattern_mode, invert
//
//  Each tick transaction updates the state and the result register at the edge
//  that accepts it, and the result is offered from the next cycle on. Input is
//  taken every cycle while the result register is empty or being drained, so
//  the output register is the only stall point. A synchronous low i_rst_n
//  clears the burst state and loads register defaults. Software must write
//  registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module gate_burst_sequencer_top #(
    parameter int OUTPUTS = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    gbs_in_if.sink           i_in,
    gbs_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    gbs_pkg::t_cfg       r_cfg;
    logic                r_valid;
    logic [OUTPUTS-1:0]  r_gates;
    logic                r_busy;

    logic                w_accept;
    logic                w_cfg_wr;
    logic [OUTPUTS-1:0]  w_gates_next;
    logic                w_running_next;
    logic [OUTPUTS-1:0]  w_gates;
    gbs_pkg::t_status    w_status;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.span         <= 3'd1;
            r_cfg.burst_passes <= 5'd0;
            r_cfg.pattern_mode <= 2'd0;
            r_cfg.invert       <= 1'b0;
        end else if (w_cfg_wr) begin
            case (gbs_pkg::t_reg_idx'(paddr[3:2]))
                gbs_pkg::REG_SPAN:   r_cfg.span         <= pwdata[2:0];
                gbs_pkg::REG_COUNT:  r_cfg.burst_passes <= pwdata[4:0];
                gbs_pkg::REG_MODE:   r_cfg.pattern_mode <= pwdata[1:0];
                gbs_pkg::REG_INVERT: r_cfg.invert       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (gbs_pkg::t_reg_idx'(paddr[3:2]))
            gbs_pkg::REG_SPAN:   prdata = {29'd0, r_cfg.span};
            gbs_pkg::REG_COUNT:  prdata = {27'd0, r_cfg.burst_passes};
            gbs_pkg::REG_MODE:   prdata = {30'd0, r_cfg.pattern_mode};
            gbs_pkg::REG_INVERT: prdata = {31'd0, r_cfg.invert};
            default:             prdata = 32'd0;
        endcase
    end

    gbs_core #(
        .OUTPUTS (OUTPUTS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_reset_level   (i_in.reset_level),
        .i_trigger_level (i_in.trigger_level),
        .i_clock_level   (i_in.clock_level),
        .i_random_word   (i_in.random_word),
        .i_cfg           (r_cfg),
        .o_gates_next    (w_gates_next),
        .o_running_next  (w_running_next),
        .o_gates         (w_gates),
        .o_status        (w_status)
    );

    // Result register: loaded with every accepted tick, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gates <= w_gates_next;
            r_busy  <= w_running_next;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.gates    = r_gates;
    assign o_out.busy_res = r_busy;

    // A tick transaction always leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_valid)
        else $error("accepted tick produced no result");

    // No gate is ever reported high outside a burst.
    a_idle_gates_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.busy_res || o_out.gates == '0))
        else $error("gate high while no burst is running");

    // Random bursts pulse one gate at a time.
    a_random_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.running && w_status.mode == gbs_pkg::MODE_RANDOM)
            |-> $onehot0(w_gates))
        else $error("more than one gate high in a random burst");

    // The core state only moves with a tick transaction.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(w_gates) && $stable(w_status))
        else $error("sequencer state changed without a tick");

endmodule

`default_nettype wire
